### sv/ipat_pkg.sv
`default_nettype none
package ipat_pkg;

  typedef struct packed {
    logic         v6;
    logic [127:0] addr;
    logic [2:0]   zstart;
    logic [3:0]   zlen;
  } ipat_item_t;

  localparam logic [6:0] CH_DOT   = 7'h2E;
  localparam logic [6:0] CH_COLON = 7'h3A;
  localparam logic [6:0] CH_LBR   = 7'h5B;
  localparam logic [6:0] CH_RBR   = 7'h5D;
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_A     = 7'h61;

  localparam logic [1:0] DP_HUND = 2'd0;
  localparam logic [1:0] DP_TENS = 2'd1;
  localparam logic [1:0] DP_UNIT = 2'd2;

  function automatic logic [3:0] dec_digit(input logic [7:0] v, input logic [1:0] pos);
    logic [1:0]  h;
    logic [7:0]  r;
    logic [15:0] p;
    logic [3:0]  t;
    logic [7:0]  u;
    h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
    r = v - 8'(h) * 8'd100;
    p = 16'(r) * 16'd205;
    t = p[14:11];
    u = r - 8'(t) * 8'd10;
    case (pos)
      DP_HUND: dec_digit = {2'b00, h};
      DP_TENS: dec_digit = t;
      default: dec_digit = u[3:0];
    endcase
  endfunction

  function automatic logic [6:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) begin
      hex_char = CH_ZERO + {3'b000, n};
    end else begin
      hex_char = CH_A + {3'b000, n} - 7'd10;
    end
  endfunction

endpackage
`default_nettype wire

### sv/ipat_front.sv
`default_nettype none
module ipat_front
  import ipat_pkg::*;
(
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,  // addr_high, addr_low
  input  wire logic         in_tuser,  // req_type
  input  wire logic         q_full,
  output logic              q_push,
  output ipat_item_t        q_item
);

  logic [15:0] grp [8];
  logic [3:0]  run_len;
  logic [3:0]  best_len;
  logic [2:0]  run_start;
  logic [2:0]  best_start;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      grp[k]   = in_tdata[63 - 16*k -: 16];
      grp[k+4] = in_tdata[127 - 16*k -: 16];
    end
  end

  // longest zero-group run, first one on a tie
  always_comb begin
    run_len    = 4'd0;
    best_len   = 4'd0;
    run_start  = 3'd0;
    best_start = 3'd0;
    for (int k = 0; k < 8; k++) begin
      if (grp[k] == 16'h0000) begin
        if (run_len == 4'd0) begin
          run_start = 3'(k);
        end
        run_len = run_len + 4'd1;
        if (run_len > best_len) begin
          best_len   = run_len;
          best_start = run_start;
        end
      end else begin
        run_len = 4'd0;
      end
    end
  end

  always_comb begin
    q_item.v6     = in_tuser;
    q_item.addr   = {in_tdata[63:0], in_tdata[127:64]};
    q_item.zstart = best_start;
    q_item.zlen   = (in_tuser && best_len >= 4'd2) ? best_len : 4'd0;
  end

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

endmodule
`default_nettype wire

### sv/ipat_queue.sv
`default_nettype none
module ipat_queue
  import ipat_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire ipat_item_t  push_item,
  output logic             full,
  input  wire logic        pop,
  output logic             valid,
  output ipat_item_t       pop_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ipat_item_t    mem_r [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_pop;

  assign full     = (cnt_r == CW'(DEPTH));
  assign valid    = (cnt_r != '0);
  assign pop_item = mem_r[rp_r];
  assign do_pop   = pop && valid;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
    end
    if (do_pop) begin
      rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_item;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("push into full queue");
`endif

endmodule
`default_nettype wire

### sv/ipat_back.sv
`default_nettype none
module ipat_back
  import ipat_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       q_valid,
  input  wire ipat_item_t q_item,
  output logic            q_pop,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // text_char, zero pad
  output logic            out_tlast   // last_char
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_OPEN  = 7'b0000010,
    S_DIGIT = 7'b0000100,
    S_SEP   = 7'b0001000,
    S_ZCOL1 = 7'b0010000,
    S_ZCOL2 = 7'b0100000,
    S_CLOSE = 7'b1000000
  } st_t;

  st_t        st_r, st_nxt;
  ipat_item_t cur_r;
  logic [2:0] idx_r, idx_nxt;
  logic [1:0] dig_r, dig_nxt;
  logic       ov_r, ov_nxt;
  logic [6:0] och_r, och_nxt;
  logic       olast_r, olast_nxt;

  logic        emit;
  ipat_item_t  ent_item;
  logic [2:0]  ent_idx;
  st_t         ent_st;
  logic [1:0]  ent_dig;
  logic [15:0] ent_grp;
  logic [7:0]  ent_oct;
  logic [15:0] cur_grp;
  logic [7:0]  cur_oct;
  logic [3:0]  zsum;
  logic        last_dig;

  assign emit  = (st_r != S_IDLE) && (!ov_r || out_tready);
  assign q_pop = (st_r == S_IDLE) && q_valid;

  assign ent_item = (st_r == S_IDLE) ? q_item : cur_r;
  assign zsum     = {1'b0, idx_r} + cur_r.zlen;

  always_comb begin
    case (st_r)
      S_SEP:   ent_idx = idx_r + 3'd1;
      S_ZCOL2: ent_idx = zsum[2:0];
      default: ent_idx = 3'd0;
    endcase
  end

  assign ent_grp = ent_item.addr[127 - 16*ent_idx -: 16];
  assign ent_oct = ent_item.addr[31 - 8*ent_idx[1:0] -: 8];
  assign cur_grp = cur_r.addr[127 - 16*idx_r -: 16];
  assign cur_oct = cur_r.addr[31 - 8*idx_r[1:0] -: 8];

  // state on arriving at a group or octet
  always_comb begin
    ent_st  = S_DIGIT;
    ent_dig = 2'd0;
    if (ent_item.v6) begin
      if (ent_item.zlen != 4'd0 && ent_idx == ent_item.zstart) begin
        ent_st = (ent_idx == 3'd0) ? S_ZCOL1 : S_ZCOL2;
      end else if (ent_grp[15:12] != 4'h0) begin
        ent_dig = 2'd3;
      end else if (ent_grp[11:8] != 4'h0) begin
        ent_dig = 2'd2;
      end else if (ent_grp[7:4] != 4'h0) begin
        ent_dig = 2'd1;
      end
    end else begin
      if (ent_oct >= 8'd100) begin
        ent_dig = DP_HUND;
      end else if (ent_oct >= 8'd10) begin
        ent_dig = DP_TENS;
      end else begin
        ent_dig = DP_UNIT;
      end
    end
  end

  assign last_dig = cur_r.v6 ? (dig_r == 2'd0) : (dig_r == DP_UNIT);

  always_comb begin
    st_nxt    = st_r;
    idx_nxt   = idx_r;
    dig_nxt   = dig_r;
    ov_nxt    = ov_r && !out_tready;
    och_nxt   = och_r;
    olast_nxt = olast_r;
    if (q_pop) begin
      idx_nxt = 3'd0;
      dig_nxt = ent_dig;
      st_nxt  = q_item.v6 ? S_OPEN : ent_st;
    end else if (emit) begin
      ov_nxt    = 1'b1;
      olast_nxt = 1'b0;
      case (st_r)
        S_OPEN: begin
          och_nxt = CH_LBR;
          st_nxt  = ent_st;
          dig_nxt = ent_dig;
        end
        S_DIGIT: begin
          if (cur_r.v6) begin
            och_nxt = hex_char(cur_grp[4*dig_r +: 4]);
            dig_nxt = dig_r - 2'd1;
          end else begin
            och_nxt = CH_ZERO + {3'b000, dec_digit(cur_oct, dig_r)};
            dig_nxt = dig_r + 2'd1;
          end
          if (last_dig) begin
            if (cur_r.v6) begin
              st_nxt = (idx_r == 3'd7) ? S_CLOSE : S_SEP;
            end else if (idx_r == 3'd3) begin
              olast_nxt = 1'b1;
              st_nxt    = S_IDLE;
            end else begin
              st_nxt = S_SEP;
            end
          end
        end
        S_SEP: begin
          och_nxt = cur_r.v6 ? CH_COLON : CH_DOT;
          idx_nxt = ent_idx;
          st_nxt  = ent_st;
          dig_nxt = ent_dig;
        end
        S_ZCOL1: begin
          och_nxt = CH_COLON;
          st_nxt  = S_ZCOL2;
        end
        S_ZCOL2: begin
          och_nxt = CH_COLON;
          if (zsum[3]) begin
            st_nxt = S_CLOSE;
          end else begin
            idx_nxt = ent_idx;
            st_nxt  = ent_st;
            dig_nxt = ent_dig;
          end
        end
        S_CLOSE: begin
          och_nxt   = CH_RBR;
          olast_nxt = 1'b1;
          st_nxt    = S_IDLE;
        end
        default: begin
          st_nxt = S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    dig_r   <= dig_nxt;
    och_r   <= och_nxt;
    olast_r <= olast_nxt;
    if (q_pop) begin
      cur_r <= q_item;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {1'b0, och_r};
  assign out_tlast  = olast_r;

`ifndef ASSERT_OFF
  a_last_char: assert property (@(posedge clk) disable iff (!rst_n)
      (ov_r && olast_r) |-> (och_r == CH_RBR || (och_r >= CH_ZERO && och_r <= CH_ZERO + 7'd9)))
    else $error("bad final character");
  a_close_ends: assert property (@(posedge clk) disable iff (!rst_n)
      (emit && st_r == S_CLOSE) |=> (st_r == S_IDLE && ov_r && olast_r))
    else $error("closing bracket did not end the address");
  a_v4_octet: assert property (@(posedge clk) disable iff (!rst_n)
      (st_r == S_DIGIT && !cur_r.v6) |-> (idx_r[2] == 1'b0 && dig_r != 2'd3))
    else $error("ipv4 octet or digit out of range");
`endif

endmodule
`default_nettype wire

### sv/ip_address_to_text.sv
// an address is queued, then loaded by the sequencer, and its characters are registered
// throughput: one character per cycle while out_tready is high, plus a load per address
// the time an address takes in the back end is set by its text length
// a queue of QUEUE_DEPTH addresses lets intake run ahead of the character sequencer
// reset: synchronous active-low rst_n empties the queue and idles the sequencer
`default_nettype none
module ip_address_to_text
  import ipat_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,  // addr_high, addr_low
  input  wire logic         in_tuser,  // req_type
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [7:0]        out_tdata, // text_char, zero pad
  output logic              out_tlast  // last_char
);

  ipat_item_t push_item;
  ipat_item_t pop_item;
  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_valid;

  ipat_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  ipat_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_item  (pop_item)
  );

  ipat_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (pop_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire
